### rtl/efom_pkg.sv
package efom_pkg;

  localparam int EVENT_SLOTS = 15;
  localparam int ORIGIN_BITS = 8;
  localparam int STORE_DEPTH = EVENT_SLOTS + 1;
  localparam int SLOT_W = $clog2(STORE_DEPTH);
  localparam int COUNT_W = $clog2(STORE_DEPTH + 1);

  localparam int ORIGIN_W = 8;
  localparam int STATUS_W = 3;
  localparam int FILL_W = 5;

  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED     = 3'd0,
    ST_MARKER     = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_POP_EVENT  = 3'd3,
    ST_POP_MARKER = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

  typedef struct packed {
    logic                   marker;
    logic [ORIGIN_BITS-1:0] origin;
  } entry_t;

endpackage

### rtl/event_fifo_overflow_marker.sv
// event fifo with overflow marker
// slave side: one beat per request, s_axis_tuser carries the action
// (push or pop) and s_axis_tdata the origin id used on push.
// master side: one beat per request with the status in m_axis_tuser and
// the popped origin plus the fill level in m_axis_tdata.
// up to 15 events are queued; a push at 15 held entries is stored as an
// overflow marker in a sixteenth slot, and pushes while all sixteen slots
// are held are dropped. a pop on an empty queue reports an empty status.
// the result beat is registered and valid in the cycle after the request beat.
// throughput: one beat per cycle while m_axis_tready stays high; the single
// result register is refilled in the same cycle it is taken, and s_axis_tready
// follows m_axis_tready whenever a result is pending.
// reset clears the count and both slot pointers and drops any pending
// result; the 16 x 9 bit slot store is not cleared.
// a stalled receiver holds the result beat and backpressures requests.
module event_fifo_overflow_marker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [efom_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // origin[7:0]
  input  logic                                s_axis_tuser,  // action[0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [efom_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // event_origin[7:0], fill_level[12:8]
  output logic [efom_pkg::STATUS_W-1:0]       m_axis_tuser   // status[2:0]
);
  import efom_pkg::*;

  entry_t                 store [STORE_DEPTH];
  logic [SLOT_W-1:0]      read_slot;
  logic [SLOT_W-1:0]      write_slot;
  logic [COUNT_W-1:0]     held_count;

  logic                   out_valid;
  status_t                out_status;
  logic [ORIGIN_W-1:0]    out_origin;
  logic [FILL_W-1:0]      out_fill;

  logic                   in_accept;
  logic                   do_write;
  logic                   do_read;
  entry_t                 rd_entry;
  entry_t                 wr_entry;
  status_t                status_next;
  logic [ORIGIN_W-1:0]    origin_next;
  logic [COUNT_W-1:0]     held_count_next;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(STORE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  always_comb begin
    do_write = 1'b0;
    do_read = 1'b0;
    rd_entry = store[read_slot];
    wr_entry.marker = (held_count == COUNT_W'(EVENT_SLOTS));
    wr_entry.origin = s_axis_tdata[ORIGIN_BITS-1:0];
    origin_next = '0;
    held_count_next = held_count;
    if (action_t'(s_axis_tuser) == ACT_PUSH) begin
      if (held_count > COUNT_W'(EVENT_SLOTS)) begin
        status_next = ST_DROPPED;
      end else begin
        do_write = 1'b1;
        held_count_next = held_count + 1'b1;
        status_next = wr_entry.marker ? ST_MARKER : ST_PUSHED;
      end
    end else begin
      if (held_count == '0) begin
        status_next = ST_EMPTY;
      end else begin
        do_read = 1'b1;
        held_count_next = held_count - 1'b1;
        origin_next = ORIGIN_W'(rd_entry.origin);
        status_next = rd_entry.marker ? ST_POP_MARKER : ST_POP_EVENT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && do_write) begin
      store[write_slot] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_slot <= '0;
      write_slot <= '0;
      held_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        out_valid <= 1'b1;
        held_count <= held_count_next;
        if (do_write) begin
          write_slot <= next_slot(write_slot);
        end
        if (do_read) begin
          read_slot <= next_slot(read_slot);
        end
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_status <= status_next;
      out_origin <= origin_next;
      out_fill <= FILL_W'(held_count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = OUT_TDATA_W'({out_fill, out_origin});

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_W'(STORE_DEPTH))
    else $error("held count above store depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (held_count == COUNT_W'(STORE_DEPTH)) ||
    (SLOT_W'((write_slot + SLOT_W'(STORE_DEPTH) - read_slot) % STORE_DEPTH)
      == SLOT_W'(held_count)))
    else $error("slot pointers disagree with held count");

  a_marker_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_MARKER |-> out_fill == FILL_W'(STORE_DEPTH))
    else $error("marker pushed below full level");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_EMPTY || out_status == ST_PUSHED ||
                  out_status == ST_MARKER || out_status == ST_DROPPED)
      |-> out_origin == '0)
    else $error("origin set on a non-pop result");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("request beat produced no result");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import efom_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [7:0]        origin;
    logic [FILL_W-1:0] fill;
  } fifo_reply_t;

  typedef struct packed {
    action_t     act;
    logic [7:0]  origin;
    logic        typed;
    fifo_reply_t reply;
  } request_row_t;

  // rows with typed = 0 take their reply from the predictor
  localparam request_row_t REQUEST_TABLE [25] = '{
    '{ACT_POP,  8'hA5, 1'b1, '{ST_EMPTY,     8'h00, 5'd0}},
    '{ACT_PUSH, 8'h00, 1'b1, '{ST_PUSHED,    8'h00, 5'd1}},
    '{ACT_POP,  8'h5A, 1'b1, '{ST_POP_EVENT, 8'h00, 5'd0}},
    '{ACT_PUSH, 8'hFF, 1'b1, '{ST_PUSHED,    8'h00, 5'd1}},
    '{ACT_POP,  8'h00, 1'b1, '{ST_POP_EVENT, 8'hFF, 5'd0}},
    '{ACT_PUSH, 8'h01, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'h02, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'h04, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'h08, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'h10, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'h20, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'h40, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'h80, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'hFE, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'hFD, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'hFB, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'hF7, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'hEF, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'hDF, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'hBF, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_PUSH, 8'h55, 1'b1, '{ST_MARKER,    8'h00, 5'd16}},
    '{ACT_PUSH, 8'hAA, 1'b1, '{ST_DROPPED,   8'h00, 5'd16}},
    '{ACT_POP,  8'hFF, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_POP,  8'h00, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}},
    '{ACT_POP,  8'h3C, 1'b0, '{ST_PUSHED,    8'h00, 5'd0}}
  };

  localparam int SEND_IDLE [4]  = '{0, 71, 0, 25};
  localparam int RECV_STALL [4] = '{0, 0, 71, 25};
  localparam int PHASE_BEATS    = 232;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;  // origin[7:0]
  logic                   s_axis_tuser;  // action[0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // event_origin[7:0], fill_level[12:8]
  logic [STATUS_W-1:0]    m_axis_tuser;  // status[2:0]

  entry_t             slot_store [STORE_DEPTH];
  logic [SLOT_W-1:0]  rd_slot;
  logic [SLOT_W-1:0]  wr_slot;
  logic [COUNT_W-1:0] held_entries;

  fifo_reply_t awaited_replies [$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_request;

  event_fifo_overflow_marker DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic fifo_reply_t next_fifo_reply(input action_t act, input logic [7:0] org);
    fifo_reply_t r;
    entry_t      e;
    r.origin = 8'h00;
    r.status = ST_EMPTY;
    if (act == ACT_PUSH) begin
      if (held_entries > EVENT_SLOTS) begin
        r.status = ST_DROPPED;
      end else begin
        e.marker = (held_entries == EVENT_SLOTS);
        e.origin = org;
        r.status = e.marker ? ST_MARKER : ST_PUSHED;
        slot_store[wr_slot] = e;
        wr_slot = (wr_slot == SLOT_W'(STORE_DEPTH - 1)) ? '0 : wr_slot + 1'b1;
        held_entries = held_entries + 1'b1;
      end
    end else if (held_entries != 0) begin
      e = slot_store[rd_slot];
      rd_slot = (rd_slot == SLOT_W'(STORE_DEPTH - 1)) ? '0 : rd_slot + 1'b1;
      held_entries = held_entries - 1'b1;
      r.origin = e.origin;
      r.status = e.marker ? ST_POP_MARKER : ST_POP_EVENT;
    end
    r.fill = FILL_W'(held_entries);
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, what);
  endtask

  // entered and left at a falling edge
  task automatic send_beat(input action_t act, input logic [7:0] org,
                           input logic typed = 1'b0, input fifo_reply_t typed_reply = '0);
    fifo_reply_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= org;
    s_axis_tuser  <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = next_fifo_reply(act, org);
    awaited_replies.push_back(typed ? typed_reply : predicted);
    @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    fifo_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_replies.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending: status %0d origin %02h fill %0d",
                                m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[12:8]));
      end else begin
        want = awaited_replies.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata[7:0] !== want.origin ||
            m_axis_tdata[12:8] !== want.fill)
          flag_mismatch($sformatf(
            "expected status %0d origin %02h fill %0d, got status %0d origin %02h fill %0d",
            want.status, want.origin, want.fill,
            m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[12:8]));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int      push_pct;
    action_t act;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ACT_PUSH;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    mismatch_count = 0;
    rd_slot        = '0;
    wr_slot        = '0;
    held_entries   = '0;
    push_pct       = 50;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (REQUEST_TABLE[i])
      send_beat(REQUEST_TABLE[i].act, REQUEST_TABLE[i].origin,
                REQUEST_TABLE[i].typed, REQUEST_TABLE[i].reply);

    for (int phase = 0; phase < 4; phase++) begin
      // sender pause until the queue of results has drained
      s_axis_tvalid <= 1'b0;
      wait (awaited_replies.size() == 0);
      @(negedge clk);
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 0 && n == 40) hold_request = 60;
        // bursts lean toward filling, draining or neither
        if (n % 24 == 0) begin
          case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 20;
            default: push_pct = 55;
          endcase
        end
        act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
        send_beat(act, 8'($urandom));
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (awaited_replies.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### event_fifo_overflow_marker.f
rtl/efom_pkg.sv
rtl/event_fifo_overflow_marker.sv
tb/sv/testbench.sv
